// ===== rtl/pfrb_pkg.sv =====
package pfrb_pkg;

  // stream widths
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 48;

  // field widths
  localparam int CODE_W  = 8;
  localparam int COLOR_W = 24;
  localparam int PADDR_W = 17;
  localparam int PHASE_W = 2;

  // input tdata layout, lowest bit first
  localparam int CODE_LSB  = 0;
  localparam int COLOR_LSB = CODE_LSB + CODE_W;
  localparam int PADDR_LSB = COLOR_LSB + COLOR_W;
  localparam int PHASE_LSB = PADDR_LSB + PADDR_W;
  localparam int FIRST_LSB = PHASE_LSB + PHASE_W;
  localparam int BANK_LSB  = FIRST_LSB + 1;

  // output tdata padding above out_address and out_color
  localparam int OUT_PAD_W = OUT_TDATA_W - PADDR_W - COLOR_W;

  // address compare width, wide enough for the largest frame size
  localparam int ADDR_EXT_W = 21;

  // queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;
  localparam int Q_CW    = 3;

  // result buffer in the back end
  localparam int OBUF_DEPTH = 4;
  localparam int OBUF_AW    = 2;
  localparam int OBUF_CW    = 3;

  // opcode carried on tuser
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  // sub-frame phases
  localparam logic [PHASE_W-1:0] PH_QUARTER = 2'd0;
  localparam logic [PHASE_W-1:0] PH_HALF    = 2'd1;
  localparam logic [PHASE_W-1:0] PH_THREE_Q = 2'd2;
  localparam logic [PHASE_W-1:0] PH_FULL    = 2'd3;

  typedef struct packed {
    logic                 is_pixel;
    logic [CODE_W-1:0]    code;
    logic [COLOR_W-1:0]   color;
    logic [PADDR_W-1:0]   addr;
    logic [PHASE_W-1:0]   phase;
    logic                 first;
    logic                 bank;
  } pfrb_item_t;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic [PADDR_W-1:0] addr;
  } pfrb_out_t;

endpackage

// ===== rtl/pfrb_front.sv =====
module pfrb_front #(
  parameter int FRAME_PIXELS = 76800
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [pfrb_pkg::IN_TDATA_W-1:0]  s_tdata,
  input  logic                             s_tuser,
  output logic                             push_valid,
  input  logic                             push_ready,
  output pfrb_pkg::pfrb_item_t             push_item
);

  logic                 f_valid;
  pfrb_pkg::pfrb_item_t f_item;
  pfrb_pkg::pfrb_item_t in_item;
  logic                 keep;
  logic [pfrb_pkg::ADDR_EXT_W-1:0] addr_ext;

  always_comb begin
    in_item.is_pixel = (s_tuser == pfrb_pkg::OP_PIXEL);
    in_item.code     = s_tdata[pfrb_pkg::CODE_LSB  +: pfrb_pkg::CODE_W];
    in_item.color    = s_tdata[pfrb_pkg::COLOR_LSB +: pfrb_pkg::COLOR_W];
    in_item.addr     = s_tdata[pfrb_pkg::PADDR_LSB +: pfrb_pkg::PADDR_W];
    in_item.phase    = s_tdata[pfrb_pkg::PHASE_LSB +: pfrb_pkg::PHASE_W];
    in_item.first    = s_tdata[pfrb_pkg::FIRST_LSB];
    in_item.bank     = s_tdata[pfrb_pkg::BANK_LSB];
  end

  // pixels beyond the frame are taken and dropped here
  assign addr_ext = {{(pfrb_pkg::ADDR_EXT_W - pfrb_pkg::PADDR_W){1'b0}}, in_item.addr};
  assign keep     = !in_item.is_pixel ||
                    (addr_ext < pfrb_pkg::ADDR_EXT_W'(FRAME_PIXELS));

  assign s_tready   = !f_valid || push_ready;
  assign push_valid = f_valid;
  assign push_item  = f_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (s_tready) begin
      f_valid <= s_tvalid && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready) begin
      f_item <= in_item;
    end
  end

endmodule

// ===== rtl/pfrb_queue.sv =====
module pfrb_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push_valid,
  output logic                 push_ready,
  input  pfrb_pkg::pfrb_item_t push_item,
  output logic                 pop_valid,
  input  logic                 pop_ready,
  output pfrb_pkg::pfrb_item_t pop_item
);

  pfrb_pkg::pfrb_item_t          slots [pfrb_pkg::Q_DEPTH];
  logic [pfrb_pkg::Q_AW-1:0]     wr_ptr;
  logic [pfrb_pkg::Q_AW-1:0]     rd_ptr;
  logic [pfrb_pkg::Q_CW-1:0]     count;
  logic                          push;
  logic                          pop;

  assign push_ready = (count != pfrb_pkg::Q_CW'(pfrb_pkg::Q_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_item;
  end

  assert property (@(posedge clk) disable iff (rst)
    count <= pfrb_pkg::Q_CW'(pfrb_pkg::Q_DEPTH))
    else $error("queue count beyond depth");

  assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count lost a push");

endmodule

// ===== rtl/pfrb_back.sv =====
module pfrb_back #(
  parameter int FRAME_PIXELS = 76800
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             q_valid,
  output logic                             q_ready,
  input  pfrb_pkg::pfrb_item_t             q_item,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [pfrb_pkg::OUT_TDATA_W-1:0] m_tdata
);

  localparam int AW = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;

  typedef logic [pfrb_pkg::COLOR_W-1:0] color_t;

  function automatic logic [AW-1:0] frame_index(input logic [pfrb_pkg::PADDR_W-1:0] a);
    logic [pfrb_pkg::ADDR_EXT_W-1:0] ext;
    ext = {{(pfrb_pkg::ADDR_EXT_W - pfrb_pkg::PADDR_W){1'b0}}, a};
    return ext[AW-1:0];
  endfunction

  // per-channel weighted mix, truncated
  function automatic color_t blend(input color_t o, input color_t n,
                                   input logic [pfrb_pkg::PHASE_W-1:0] ph);
    logic [9:0] so;
    logic [9:0] sn;
    logic [9:0] s;
    color_t     r;
    r = '0;
    for (int k = 0; k < 3; k++) begin
      so = {2'b00, o[8*k +: 8]};
      sn = {2'b00, n[8*k +: 8]};
      case (ph)
        pfrb_pkg::PH_QUARTER: s = ((so << 1) + so + sn) >> 2;
        pfrb_pkg::PH_HALF:    s = (so + sn) >> 1;
        pfrb_pkg::PH_THREE_Q: s = (so + (sn << 1) + sn) >> 2;
        default:              s = so;
      endcase
      r[8*k +: 8] = s[7:0];
    end
    return r;
  endfunction

  color_t palette [256];
  color_t frame0  [FRAME_PIXELS];
  color_t frame1  [FRAME_PIXELS];

  logic                         pop;
  logic                         space;
  logic [pfrb_pkg::OBUF_CW-1:0] committed;
  logic [AW-1:0]                pop_idx;

  // stage A: the cycle after the pop, memory data available
  logic                 a_valid;
  pfrb_pkg::pfrb_item_t a_item;
  color_t               pal_rd;
  color_t               f0_rd;
  color_t               f1_rd;
  logic                 fwd0;
  logic                 fwd1;
  color_t               fwd_data;

  color_t        f0_v;
  color_t        f1_v;
  color_t        old_c;
  color_t        new_c;
  color_t        res_c;
  logic          wr_en;
  logic          wr_bank;
  logic [AW-1:0] a_idx;

  pfrb_pkg::pfrb_out_t          obuf [pfrb_pkg::OBUF_DEPTH];
  logic [pfrb_pkg::OBUF_AW-1:0] o_wr;
  logic [pfrb_pkg::OBUF_AW-1:0] o_rd;
  logic [pfrb_pkg::OBUF_CW-1:0] o_count;
  logic                         o_pop;
  pfrb_pkg::pfrb_out_t          o_head;

  // a pixel is only issued when its result is sure of a buffer slot
  assign committed = o_count + pfrb_pkg::OBUF_CW'(a_valid);
  assign space     = committed < pfrb_pkg::OBUF_CW'(pfrb_pkg::OBUF_DEPTH);
  assign q_ready   = !q_item.is_pixel || space;
  assign pop       = q_valid && q_ready;
  assign pop_idx   = frame_index(q_item.addr);

  always_ff @(posedge clk) begin
    if (pop && !q_item.is_pixel) palette[q_item.code] <= q_item.color;
    if (pop) pal_rd <= palette[q_item.code];
  end

  always_ff @(posedge clk) begin
    if (wr_en && !wr_bank) frame0[a_idx] <= pal_rd;
    if (pop) f0_rd <= frame0[pop_idx];
  end

  always_ff @(posedge clk) begin
    if (wr_en && wr_bank) frame1[a_idx] <= pal_rd;
    if (pop) f1_rd <= frame1[pop_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= pop && q_item.is_pixel;
    end
  end

  // the entry written this cycle is read stale by the item popped now
  always_ff @(posedge clk) begin
    if (pop) begin
      a_item   <= q_item;
      fwd0     <= wr_en && !wr_bank && (a_idx == pop_idx);
      fwd1     <= wr_en &&  wr_bank && (a_idx == pop_idx);
      fwd_data <= pal_rd;
    end
  end

  always_comb begin
    a_idx = frame_index(a_item.addr);
    f0_v  = fwd0 ? fwd_data : f0_rd;
    f1_v  = fwd1 ? fwd_data : f1_rd;
    old_c = a_item.bank ? f1_v : f0_v;
    new_c = a_item.bank ? f0_v : f1_v;
    wr_en   = 1'b0;
    wr_bank = a_item.bank;
    case (a_item.phase)
      pfrb_pkg::PH_QUARTER: begin
        wr_en   = a_valid;
        wr_bank = !a_item.bank;
        res_c   = blend(old_c, pal_rd, a_item.phase);
      end
      pfrb_pkg::PH_HALF, pfrb_pkg::PH_THREE_Q: begin
        res_c = blend(old_c, new_c, a_item.phase);
      end
      default: begin
        wr_en = a_valid && a_item.first;
        res_c = a_item.first ? pal_rd : old_c;
      end
    endcase
  end

  assign o_head   = obuf[o_rd];
  assign m_tvalid = (o_count != '0);
  assign m_tdata  = {{pfrb_pkg::OUT_PAD_W{1'b0}}, o_head.color, o_head.addr};
  assign o_pop    = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_wr    <= '0;
      o_rd    <= '0;
      o_count <= '0;
    end else begin
      if (a_valid) o_wr <= o_wr + 1'b1;
      if (o_pop)   o_rd <= o_rd + 1'b1;
      case ({a_valid, o_pop})
        2'b10:   o_count <= o_count + 1'b1;
        2'b01:   o_count <= o_count - 1'b1;
        default: o_count <= o_count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (a_valid) begin
      obuf[o_wr].addr  <= a_item.addr;
      obuf[o_wr].color <= res_c;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    o_count <= pfrb_pkg::OBUF_CW'(pfrb_pkg::OBUF_DEPTH))
    else $error("result buffer count beyond depth");

  assert property (@(posedge clk) disable iff (rst)
    a_valid |-> (o_count != pfrb_pkg::OBUF_CW'(pfrb_pkg::OBUF_DEPTH)))
    else $error("result written into a full buffer");

  assert property (@(posedge clk) disable iff (rst)
    a_valid |-> !(fwd0 && fwd1))
    else $error("forwarding into both banks");

endmodule

// ===== rtl/palette_frame_rate_blender_core.sv =====
// Palette frame-rate blender: quadruples a palettised frame rate by blending
// the stored frame with the newly decoded one, one pixel per transaction.
// Slave stream: tuser is the opcode (0 palette load, 1 pixel). A load writes
// entry_color into palette entry code_byte and gives no result. A pixel gives
// one result on the master stream: its address and the blended colour.
// Pixels whose address is at or beyond FRAME_PIXELS are taken and dropped.
// Throughput: one transaction per clock on either side while the receiver
// keeps m_tready high, loads and pixels mixed freely; the palette and the two
// frame banks each do one read and one write per cycle, with a bypass for a
// frame entry written by the pixel just ahead.
// A result passes the input register, the queue and the memory read, and is
// blended into the result buffer, from which it is offered.
// When the receiver stalls, up to 4 results wait in the result buffer and
// the queue and input register fill behind them; s_tready then drops.
// Reset clears all handshake state; the palette and frame banks keep their
// contents and must be written before they are read.
module palette_frame_rate_blender_core #(
  parameter int FRAME_PIXELS = 76800
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // code_byte, entry_color, pixel_address, phase, first_frame, bank, zero pad
  input  logic [pfrb_pkg::IN_TDATA_W-1:0]  s_tdata,
  // opcode
  input  logic                             s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // out_address, out_color, zero pad
  output logic [pfrb_pkg::OUT_TDATA_W-1:0] m_tdata
);

  logic                 push_valid;
  logic                 push_ready;
  pfrb_pkg::pfrb_item_t push_item;
  logic                 q_valid;
  logic                 q_ready;
  pfrb_pkg::pfrb_item_t q_item;

  pfrb_front #(
    .FRAME_PIXELS (FRAME_PIXELS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  pfrb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  pfrb_back #(
    .FRAME_PIXELS (FRAME_PIXELS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// ===== sim/tb_palette_frame_rate_blender_core.sv =====
`timescale 1ns / 100ps

module tb_palette_frame_rate_blender_core;

  localparam int FRAME_PIXELS = 76800;
  localparam int N_ITEMS      = 2000;
  localparam int ADDR_POOL    = 32;
  localparam int CYCLE_LIMIT  = 600000;

  logic                             clk;
  logic                             rst      = 1'b1;
  logic                             s_tvalid = 1'b0;
  logic                             s_tready;
  logic [pfrb_pkg::IN_TDATA_W-1:0]  s_tdata  = '0;
  logic                             s_tuser  = 1'b0;
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  logic [pfrb_pkg::OUT_TDATA_W-1:0] m_tdata;

  palette_frame_rate_blender_core #(
    .FRAME_PIXELS(FRAME_PIXELS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Tracks palette and both frame banks, predicts the blended pixel for every
  // accepted pixel within the frame and compares results in order.
  class blend_scoreboard;
    bit [pfrb_pkg::COLOR_W-1:0] palette [256];
    bit [pfrb_pkg::COLOR_W-1:0] frames [2][FRAME_PIXELS];
    pfrb_pkg::pfrb_out_t        expected_q[$];
    int                         errors;
    int                         checked;

    function bit [pfrb_pkg::COLOR_W-1:0] mix(bit [pfrb_pkg::COLOR_W-1:0] a,
                                             bit [pfrb_pkg::COLOR_W-1:0] b,
                                             int unsigned wa, int unsigned wb,
                                             int unsigned sh);
      bit [pfrb_pkg::COLOR_W-1:0] r;
      int unsigned                v;
      for (int k = 0; k < 3; k++) begin
        v = (a[8*k +: 8] * wa + b[8*k +: 8] * wb) >> sh;
        r[8*k +: 8] = v[7:0];
      end
      return r;
    endfunction

    function void note_transaction(pfrb_pkg::pfrb_item_t it);
      bit [pfrb_pkg::COLOR_W-1:0] older;
      bit [pfrb_pkg::COLOR_W-1:0] newer;
      pfrb_pkg::pfrb_out_t        res;
      if (it.is_pixel == pfrb_pkg::OP_LOAD) begin
        palette[it.code] = it.color;
        return;
      end
      if (it.addr >= FRAME_PIXELS)
        return;
      if (it.phase == pfrb_pkg::PH_QUARTER)
        frames[it.bank ^ 1'b1][it.addr] = palette[it.code];
      else if (it.phase == pfrb_pkg::PH_FULL && it.first)
        frames[it.bank][it.addr] = palette[it.code];
      older = frames[it.bank][it.addr];
      newer = frames[it.bank ^ 1'b1][it.addr];
      case (it.phase)
        pfrb_pkg::PH_QUARTER: res.color = mix(older, newer, 3, 1, 2);
        pfrb_pkg::PH_HALF:    res.color = mix(older, newer, 1, 1, 1);
        pfrb_pkg::PH_THREE_Q: res.color = mix(older, newer, 1, 3, 2);
        default:              res.color = older;
      endcase
      res.addr = it.addr;
      expected_q.push_back(res);
    endfunction

    function void check_pixel(logic [pfrb_pkg::OUT_TDATA_W-1:0] data);
      pfrb_pkg::pfrb_out_t          exp_px;
      logic [pfrb_pkg::PADDR_W-1:0] got_addr;
      logic [pfrb_pkg::COLOR_W-1:0] got_color;
      got_addr  = data[pfrb_pkg::PADDR_W-1:0];
      got_color = data[pfrb_pkg::PADDR_W +: pfrb_pkg::COLOR_W];
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, got addr %05h colour %06h",
                 $time, got_addr, got_color);
        errors++;
        return;
      end
      exp_px = expected_q.pop_front();
      checked++;
      if (got_addr !== exp_px.addr) begin
        $display("%0t: out_address mismatch, expected %05h, got %05h",
                 $time, exp_px.addr, got_addr);
        errors++;
      end
      if (got_color !== exp_px.color) begin
        $display("%0t: out_color mismatch at addr %05h, expected %06h, got %06h",
                 $time, exp_px.addr, exp_px.color, got_color);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  blend_scoreboard sb = new();

  // what the stimulus has already written, so nothing unwritten is ever read
  bit                           pal_written [256];
  bit                           fr_written [2][FRAME_PIXELS];
  logic [7:0]                   loaded_codes[$];
  logic [pfrb_pkg::PADDR_W-1:0] addr_pool [ADDR_POOL];

  bit tx_calm;
  bit rx_calm;
  int stall_left;
  int cycle_count;
  int n_loads, n_pixels, n_dropped;
  int phase_hits [4];

  function automatic int pick_gap(bit calm);
    int r;
    if (calm)
      return 0;
    r = $urandom_range(99);
    if (r < 55)
      return 0;
    if (r < 88)
      return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, sb.pending());
      $display("tb_palette_frame_rate_blender_core: errors");
      $finish;
    end
  end

  // receiving side: check each transaction, then stall at random
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_pixel(m_tdata);
    if ($urandom_range(299) == 0)
      rx_calm = !rx_calm;
    if (rst) begin
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else begin
      m_tready <= 1'b1;
      if (!rx_calm && $urandom_range(99) < 25)
        stall_left = pick_gap(1'b0);
    end
  end

  function automatic pfrb_pkg::pfrb_item_t mk(logic op, logic [7:0] code,
                                              logic [23:0] color, logic [16:0] addr,
                                              logic [1:0] ph, logic first,
                                              logic bank);
    pfrb_pkg::pfrb_item_t it;
    it.is_pixel = op;
    it.code     = code;
    it.color    = color;
    it.addr     = addr;
    it.phase    = ph;
    it.first    = first;
    it.bank     = bank;
    return it;
  endfunction

  // Bend a pixel so that it only reads entries written earlier, then record
  // what it writes.
  function automatic void make_legal(inout pfrb_pkg::pfrb_item_t it);
    if (it.is_pixel == pfrb_pkg::OP_LOAD) begin
      if (!pal_written[it.code])
        loaded_codes.push_back(it.code);
      pal_written[it.code] = 1'b1;
      return;
    end
    if (it.addr >= FRAME_PIXELS)
      return;
    if (!fr_written[it.bank][it.addr]) begin
      it.phase = pfrb_pkg::PH_FULL;
      it.first = 1'b1;
    end else if ((it.phase == pfrb_pkg::PH_HALF || it.phase == pfrb_pkg::PH_THREE_Q) &&
                 !fr_written[it.bank ^ 1'b1][it.addr]) begin
      it.phase = pfrb_pkg::PH_QUARTER;
    end
    if ((it.phase == pfrb_pkg::PH_QUARTER ||
         (it.phase == pfrb_pkg::PH_FULL && it.first)) &&
        !pal_written[it.code])
      it.code = loaded_codes[$urandom_range(loaded_codes.size() - 1)];
    if (it.phase == pfrb_pkg::PH_QUARTER)
      fr_written[it.bank ^ 1'b1][it.addr] = 1'b1;
    else if (it.phase == pfrb_pkg::PH_FULL && it.first)
      fr_written[it.bank][it.addr] = 1'b1;
  endfunction

  task automatic send(input pfrb_pkg::pfrb_item_t it, input int gap);
    make_legal(it);
    if (it.is_pixel == pfrb_pkg::OP_LOAD)
      n_loads++;
    else if (it.addr >= FRAME_PIXELS)
      n_dropped++;
    else begin
      n_pixels++;
      phase_hits[it.phase]++;
    end
    s_tvalid <= 1'b1;
    s_tuser  <= it.is_pixel;
    s_tdata  <= {3'b000, it.bank, it.first, it.phase, it.addr, it.color, it.code};
    do @(posedge clk); while (!s_tready);
    sb.note_transaction(it);
    // keep tvalid high when the next transaction follows straight on
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    pfrb_pkg::pfrb_item_t directed[$];
    pfrb_pkg::pfrb_item_t it;
    logic [1:0]           seq_phase;
    logic                 seq_bank;
    int                   run_left;
    int                   r;

    addr_pool[0] = 17'd0;
    addr_pool[1] = 17'(FRAME_PIXELS - 1);
    for (int i = 2; i < ADDR_POOL; i++)
      addr_pool[i] = 17'($urandom_range(FRAME_PIXELS - 1));

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // extremes of the palette, a full blend cycle on the first pixel in bank 0
    // and the last in bank 1, dropped addresses, first_frame ignored off phase 3
    directed.push_back(mk(pfrb_pkg::OP_LOAD,  8'h00, 24'h000000, '0, '0, 1'b0, 1'b0));
    directed.push_back(mk(pfrb_pkg::OP_LOAD,  8'hFF, 24'hFFFFFF, '1, '1, 1'b1, 1'b1));
    directed.push_back(mk(pfrb_pkg::OP_LOAD,  8'h5A, 24'h80FF01, '0, '0, 1'b0, 1'b0));
    directed.push_back(mk(pfrb_pkg::OP_LOAD,  8'hA5, 24'h7F0080, '0, '0, 1'b0, 1'b0));
    directed.push_back(mk(pfrb_pkg::OP_PIXEL, 8'hFF, 24'h000000, 17'd0,
                          pfrb_pkg::PH_FULL, 1'b1, 1'b0));
    directed.push_back(mk(pfrb_pkg::OP_PIXEL, 8'h00, 24'hFFFFFF, 17'd0,
                          pfrb_pkg::PH_QUARTER, 1'b1, 1'b0));
    directed.push_back(mk(pfrb_pkg::OP_PIXEL, 8'h00, 24'h000000, 17'd0,
                          pfrb_pkg::PH_HALF, 1'b0, 1'b0));
    directed.push_back(mk(pfrb_pkg::OP_PIXEL, 8'h00, 24'h000000, 17'd0,
                          pfrb_pkg::PH_THREE_Q, 1'b1, 1'b0));
    directed.push_back(mk(pfrb_pkg::OP_PIXEL, 8'h00, 24'h000000, 17'd0,
                          pfrb_pkg::PH_FULL, 1'b0, 1'b0));
    directed.push_back(mk(pfrb_pkg::OP_PIXEL, 8'hA5, 24'h000000, 17'(FRAME_PIXELS - 1),
                          pfrb_pkg::PH_FULL, 1'b1, 1'b1));
    directed.push_back(mk(pfrb_pkg::OP_PIXEL, 8'h5A, 24'h000000, 17'(FRAME_PIXELS - 1),
                          pfrb_pkg::PH_QUARTER, 1'b0, 1'b1));
    directed.push_back(mk(pfrb_pkg::OP_PIXEL, 8'h00, 24'h000000, 17'(FRAME_PIXELS - 1),
                          pfrb_pkg::PH_HALF, 1'b1, 1'b1));
    directed.push_back(mk(pfrb_pkg::OP_PIXEL, 8'h00, 24'h000000, 17'(FRAME_PIXELS - 1),
                          pfrb_pkg::PH_THREE_Q, 1'b0, 1'b1));
    directed.push_back(mk(pfrb_pkg::OP_PIXEL, 8'h00, 24'h000000, 17'(FRAME_PIXELS - 1),
                          pfrb_pkg::PH_FULL, 1'b0, 1'b1));
    directed.push_back(mk(pfrb_pkg::OP_PIXEL, 8'hFF, 24'h000000, 17'(FRAME_PIXELS),
                          pfrb_pkg::PH_QUARTER, 1'b0, 1'b0));
    directed.push_back(mk(pfrb_pkg::OP_PIXEL, 8'hFF, 24'hFFFFFF, 17'h1FFFF,
                          pfrb_pkg::PH_FULL, 1'b1, 1'b1));
    directed.push_back(mk(pfrb_pkg::OP_LOAD,  8'hFF, 24'h000000, '0, '0, 1'b0, 1'b0));
    directed.push_back(mk(pfrb_pkg::OP_PIXEL, 8'hFF, 24'h000000, 17'd0,
                          pfrb_pkg::PH_QUARTER, 1'b0, 1'b1));
    directed.push_back(mk(pfrb_pkg::OP_PIXEL, 8'h00, 24'h000000, 17'd0,
                          pfrb_pkg::PH_FULL, 1'b1, 1'b1));
    foreach (directed[i])
      send(directed[i], 0);

    // mostly runs of pixels walking through the phases like real sub-frames,
    // with loads, stray phases and dropped addresses mixed in
    seq_phase = pfrb_pkg::PH_QUARTER;
    seq_bank  = 1'b0;
    run_left  = $urandom_range(1, 12);
    while (n_loads + n_pixels < N_ITEMS + directed.size()) begin
      it = mk(1'($urandom), 8'($urandom), 24'($urandom), 17'($urandom),
              2'($urandom), 1'($urandom), 1'($urandom));
      if ($urandom_range(99) < 22) begin
        it.is_pixel = pfrb_pkg::OP_LOAD;
      end else begin
        it.is_pixel = pfrb_pkg::OP_PIXEL;
        r = $urandom_range(99);
        if (r < 3)
          it.addr = 17'($urandom_range(17'h1FFFF, FRAME_PIXELS));
        else if (r < 8)
          it.addr = 17'($urandom_range(FRAME_PIXELS - 1));
        else
          it.addr = addr_pool[$urandom_range(ADDR_POOL - 1)];
        if ($urandom_range(99) < 70) begin
          it.phase = seq_phase;
          it.bank  = seq_bank;
          run_left--;
          if (run_left == 0) begin
            if (seq_phase == pfrb_pkg::PH_FULL)
              seq_bank = !seq_bank;
            seq_phase++;
            run_left = $urandom_range(1, 12);
          end
        end
      end
      if ($urandom_range(149) == 0)
        tx_calm = !tx_calm;
      send(it, pick_gap(tx_calm));
    end
    s_tvalid <= 1'b0;

    while (sb.pending() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);

    $display("sent %0d palette loads and %0d pixels (phases 0-3: %0d/%0d/%0d/%0d), %0d dropped",
             n_loads, n_pixels, phase_hits[0], phase_hits[1], phase_hits[2],
             phase_hits[3], n_dropped);
    $display("compared %0d blended pixels, %0d mismatches", sb.checked, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("tb_palette_frame_rate_blender_core: clean");
    else
      $display("tb_palette_frame_rate_blender_core: errors");
    $finish;
  end

endmodule
